>>> src/cft_pkg.sv
// cft_pkg: types and constants shared by the connection flow tracker
// command codes, entry layout, protocol and timeout constants, controller states
// no dependencies
`default_nettype none

package cft_pkg;

	typedef enum logic [1:0] {
		CMD_PACKET = 2'd0,
		CMD_SWEEP  = 2'd1,
		CMD_FLUSH  = 2'd2,
		CMD_RSVD   = 2'd3
	} cmd_t;

	localparam logic [1:0] CFG_BYTE_LIMIT = 2'd0;
	localparam logic [1:0] CFG_PKT_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_LONG_IDLE  = 2'd2;

	localparam logic [31:0] RST_BYTE_LIMIT = 32'd500000;
	localparam logic [31:0] RST_PKT_LIMIT  = 32'd20;
	localparam logic [31:0] RST_LONG_IDLE  = 32'd300;

	localparam logic [1:0] VERDICT_NONE   = 2'd0;
	localparam logic [1:0] VERDICT_CLIENT = 2'd1;
	localparam logic [1:0] VERDICT_SERVER = 2'd2;

	localparam logic [7:0] FLAG_FIN     = 8'h01;
	localparam logic [7:0] FLAG_RST     = 8'h04;
	localparam logic [7:0] FLAG_SYN_ACK = 8'h12;

	localparam logic [7:0] PROTO_TCP   = 8'd6;
	localparam logic [7:0] PROTO_UDP   = 8'd17;
	localparam logic [7:0] PROTO_ICMP  = 8'd1;
	localparam logic [7:0] PROTO_ICMP6 = 8'd58;

	localparam logic [31:0] IDLE_CLOSED    = 32'd5;
	localparam logic [31:0] IDLE_HALF_OPEN = 32'd10;
	localparam logic [31:0] IDLE_OPEN      = 32'd120;
	localparam logic [31:0] IDLE_SHORT     = 32'd60;

	typedef struct packed {
		logic        valid;
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [31:0] ports;
		logic [7:0]  proto;
		logic [15:0] flags;
		logic [31:0] fwd_bytes;
		logic [31:0] fwd_pkts;
		logic [31:0] rev_bytes;
		logic [31:0] rev_pkts;
		logic [31:0] last_time;
		logic [63:0] serial;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_HSUM,
		ST_HMOD,
		ST_RD,
		ST_SCAN,
		ST_UPD,
		ST_WR,
		ST_SW_RD,
		ST_SW_CHK,
		ST_SW_WR,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> src/cft_if.sv
// cft_if: valid/ready channels of the connection flow tracker
// packet/command items in, result items out, register writes
// depends on nothing
`default_nettype none

interface cft_pkt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic        is_ipv6;
	logic [63:0] src_ip_hi;
	logic [63:0] src_ip_lo;
	logic [63:0] dst_ip_hi;
	logic [63:0] dst_ip_lo;
	logic [15:0] sport;
	logic [15:0] dport;
	logic [7:0]  ip_protocol;
	logic [15:0] payload_bytes;
	logic [7:0]  tcp_flag_bits;
	logic [31:0] now_seconds;

	modport source (output valid, cmd, is_ipv6, src_ip_hi, src_ip_lo, dst_ip_hi, dst_ip_lo,
		sport, dport, ip_protocol, payload_bytes, tcp_flag_bits, now_seconds,
		input ready);
	modport sink (input valid, cmd, is_ipv6, src_ip_hi, src_ip_lo, dst_ip_hi, dst_ip_lo,
		sport, dport, ip_protocol, payload_bytes, tcp_flag_bits, now_seconds,
		output ready);
endinterface

interface cft_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic        entry_replaced;
	logic [12:0] removed_count;

	modport source (output valid, verdict, entry_replaced, removed_count, input ready);
	modport sink (input valid, verdict, entry_replaced, removed_count, output ready);
endinterface

interface cft_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/connection_flow_tracker_unit.sv
// Connection flow tracker: hashed table of BUCKETS rows of WAYS entries, held in one
// row-wide synchronous memory (one read or one write a cycle, registered read data).
// One item at a time. A packet is hashed, reduced to a row index (by remainder, 4 bits a
// cycle, when BUCKETS is not a power of two), read, scanned, updated and written back;
// the ways of the row are scanned one a cycle for the newest match and the oldest entry.
// A sweep or flush walks every row, with a read, a check and a write back for each row.
// After reset a clearing pass zeroes the table; no item is taken meanwhile, but
// register writes are. The result register lets a finished item wait for the sink.
// Depends on cft_pkg and cft_if.
`default_nettype none

module connection_flow_tracker_unit import cft_pkg::*; #(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4
) (
	input  wire       clk,
	input  wire       arst_n,
	cft_pkt_if.sink   pkt,
	cft_res_if.source res,
	cft_cfg_if.sink   cfg
);

	localparam int ROW_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int REM_W   = ROW_W + 1;
	localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	// register file
	logic [31:0] byte_lim_q, pkt_lim_q, long_idle_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_lim_q  <= RST_BYTE_LIMIT;
			pkt_lim_q   <= RST_PKT_LIMIT;
			long_idle_q <= RST_LONG_IDLE;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BYTE_LIMIT: byte_lim_q  <= cfg.data;
				CFG_PKT_LIMIT:  pkt_lim_q   <= cfg.data;
				CFG_LONG_IDLE:  long_idle_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// table memory
	entry_t [WAYS-1:0] mem [BUCKETS];
	entry_t [WAYS-1:0] rd_row_q;
	entry_t [WAYS-1:0] wr_row;
	logic              rd_en, mem_we;
	logic [ROW_W-1:0]  row_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[row_q] <= wr_row;
		if (rd_en)
			rd_row_q <= mem[row_q];
	end

	// captured item
	cmd_t        cmd_q;
	logic        v6_q;
	logic [63:0] sh_q, sl_q, dh_q, dl_q;
	logic [15:0] sp_q, dp_q, bytes_q;
	logic [7:0]  proto_q, flags_q;
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			cmd_q   <= cmd_t'(pkt.cmd);
			v6_q    <= pkt.is_ipv6;
			sh_q    <= pkt.src_ip_hi;
			sl_q    <= pkt.src_ip_lo;
			dh_q    <= pkt.dst_ip_hi;
			dl_q    <= pkt.dst_ip_lo;
			sp_q    <= pkt.sport;
			dp_q    <= pkt.dport;
			proto_q <= pkt.ip_protocol;
			bytes_q <= pkt.payload_bytes;
			flags_q <= pkt.tcp_flag_bits;
			now_q   <= pkt.now_seconds;
		end
	end

	state_t st_q, st_d;
	logic   row_last;

	assign row_last = row_q == ROW_W'(BUCKETS - 1);

	// hashing
	logic [31:0]      hsum, sum_q;
	logic [REM_W-1:0] rem_q, rem_step;
	logic [2:0]       hcnt_q;

	always_comb begin
		hsum = sh_q[63:32] + dh_q[63:32];
		if (v6_q)
			hsum = hsum + sh_q[31:0] + sl_q[63:32] + sl_q[31:0]
				+ dh_q[31:0] + dl_q[63:32] + dl_q[31:0];
	end

	// restoring remainder, four hash-sum bits a cycle
	always_comb begin
		rem_step = rem_q;
		for (int k = 0; k < 4; k++) begin
			rem_step = {rem_step[REM_W-2:0], sum_q[31-k]};
			if (rem_step >= REM_W'(BUCKETS))
				rem_step = rem_step - REM_W'(BUCKETS);
		end
	end

	// way scan
	logic [WAY_W-1:0] way_q, best_way_q, inv_way_q, old_way_q, sel_way_q;
	logic             best_v_q, best_fw_q, inv_v_q;
	logic [63:0]      best_ser_q, old_ser_q, serial_q;
	entry_t           cur;
	logic             fw, rv;

	always_comb begin
		cur = rd_row_q[way_q];
		fw  = cur.ports == {sp_q, dp_q};
		rv  = cur.ports == {dp_q, sp_q};
		if (v6_q) begin
			fw = fw && cur.src_hi == sh_q && cur.src_lo == sl_q
				&& cur.dst_hi == dh_q && cur.dst_lo == dl_q;
			rv = rv && cur.src_hi == dh_q && cur.src_lo == dl_q
				&& cur.dst_hi == sh_q && cur.dst_lo == sl_q;
		end else begin
			fw = fw && cur.src_hi[63:32] == sh_q[63:32] && cur.dst_hi[63:32] == dh_q[63:32];
			rv = rv && cur.src_hi[63:32] == dh_q[63:32] && cur.dst_hi[63:32] == sh_q[63:32];
		end
	end

	// entry update
	entry_t     sel_e, upd_q, upd_d;
	logic [WAY_W-1:0] sel_way;
	logic       miss_full_q;

	always_comb begin
		if (best_v_q)
			sel_way = best_way_q;
		else if (inv_v_q)
			sel_way = inv_way_q;
		else
			sel_way = old_way_q;
		sel_e = rd_row_q[sel_way];
		upd_d = sel_e;
		if (best_v_q) begin
			upd_d.last_time = now_q;
			if (best_fw_q) begin
				upd_d.flags     = sel_e.flags | {8'h00, flags_q};
				upd_d.fwd_bytes = sel_e.fwd_bytes + {16'h0000, bytes_q};
				upd_d.fwd_pkts  = sel_e.fwd_pkts + 32'd1;
			end else begin
				upd_d.flags     = sel_e.flags | {flags_q, 8'h00};
				upd_d.rev_bytes = sel_e.rev_bytes + {16'h0000, bytes_q};
				upd_d.rev_pkts  = sel_e.rev_pkts + 32'd1;
			end
		end else begin
			upd_d.valid     = 1'b1;
			upd_d.src_hi    = sh_q;
			upd_d.src_lo    = sl_q;
			upd_d.dst_hi    = dh_q;
			upd_d.dst_lo    = dl_q;
			upd_d.ports     = {sp_q, dp_q};
			upd_d.proto     = proto_q;
			upd_d.flags     = {8'h00, flags_q};
			upd_d.fwd_bytes = {16'h0000, bytes_q};
			upd_d.fwd_pkts  = 32'd1;
			upd_d.rev_bytes = 32'd0;
			upd_d.rev_pkts  = 32'd0;
			upd_d.last_time = now_q;
			upd_d.serial    = serial_q + 64'd1;
		end
	end

	// idle expiry or flush, every way of the row at once
	logic [WAYS-1:0] kill, kill_q;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			logic [31:0] idle;
			logic [7:0]  sf, df;
			logic        out;
			idle = (now_q >= rd_row_q[w].last_time) ? now_q - rd_row_q[w].last_time : 32'd0;
			sf   = rd_row_q[w].flags[7:0];
			df   = rd_row_q[w].flags[15:8];
			if (rd_row_q[w].proto == PROTO_TCP) begin
				if ((sf & FLAG_FIN) != 8'h00 && (df & FLAG_FIN) != 8'h00 && idle > IDLE_CLOSED)
					out = 1'b1;
				else if (((sf | df) & FLAG_RST) != 8'h00 && idle > IDLE_CLOSED)
					out = 1'b1;
				else if (((sf & FLAG_SYN_ACK) == 8'h00 || (df & FLAG_SYN_ACK) == 8'h00)
						&& idle > IDLE_HALF_OPEN)
					out = 1'b1;
				else if (((sf | df) & FLAG_SYN_ACK) != 8'h00 && idle > IDLE_OPEN)
					out = 1'b1;
				else
					out = idle > long_idle_q;
			end else if (rd_row_q[w].proto == PROTO_UDP && idle > IDLE_SHORT) begin
				out = 1'b1;
			end else if (rd_row_q[w].proto == PROTO_ICMP || rd_row_q[w].proto == PROTO_ICMP6) begin
				out = idle > IDLE_SHORT;
			end else begin
				out = idle > long_idle_q;
			end
			kill[w] = rd_row_q[w].valid && (cmd_q == CMD_FLUSH || out);
		end
	end

	// write-back row
	always_comb begin
		wr_row = rd_row_q;
		if (st_q == ST_CLR) begin
			wr_row = '0;
		end else if (st_q == ST_WR) begin
			wr_row[sel_way_q] = upd_q;
		end else begin
			for (int w = 0; w < WAYS; w++)
				wr_row[w].valid = rd_row_q[w].valid && !kill_q[w];
		end
	end

	// pending result and result register
	logic [1:0]  vrd_q;
	logic        rep_q;
	logic [12:0] rm_q;
	logic        res_v_q;
	logic [1:0]  res_vrd_q;
	logic        res_rep_q;
	logic [12:0] res_rm_q;
	logic        res_load;

	assign res.valid          = res_v_q;
	assign res.verdict        = res_vrd_q;
	assign res.entry_replaced = res_rep_q;
	assign res.removed_count  = res_rm_q;

	// controller
	always_comb begin
		st_d      = st_q;
		pkt.ready = 1'b0;
		rd_en     = 1'b0;
		mem_we    = 1'b0;
		res_load  = 1'b0;
		case (st_q)
			ST_CLR: begin
				mem_we = 1'b1;
				if (row_last)
					st_d = ST_IDLE;
			end
			ST_IDLE: begin
				pkt.ready = 1'b1;
				if (pkt.valid) begin
					case (cmd_t'(pkt.cmd))
						CMD_PACKET:           st_d = ST_HSUM;
						CMD_SWEEP, CMD_FLUSH: st_d = ST_SW_RD;
						default:              st_d = ST_DONE;
					endcase
				end
			end
			ST_HSUM:   st_d = IS_POW2 ? ST_RD : ST_HMOD;
			ST_HMOD: begin
				if (hcnt_q == 3'd7)
					st_d = ST_RD;
			end
			ST_RD: begin
				rd_en = 1'b1;
				st_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (way_q == WAY_W'(WAYS - 1))
					st_d = ST_UPD;
			end
			ST_UPD:    st_d = ST_WR;
			ST_WR: begin
				mem_we = 1'b1;
				st_d   = ST_DONE;
			end
			ST_SW_RD: begin
				rd_en = 1'b1;
				st_d  = ST_SW_CHK;
			end
			ST_SW_CHK: st_d = ST_SW_WR;
			ST_SW_WR: begin
				mem_we = 1'b1;
				st_d   = row_last ? ST_DONE : ST_SW_RD;
			end
			ST_DONE: begin
				if (!res_v_q || res.ready) begin
					res_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_CLR;
		else
			st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			serial_q <= '0;
			res_v_q  <= 1'b0;
		end else begin
			if (res_load)
				res_v_q <= 1'b1;
			else if (res.ready)
				res_v_q <= 1'b0;
			case (st_q)
				ST_CLR:    row_q <= row_last ? '0 : row_q + ROW_W'(1);
				ST_IDLE:   row_q <= '0;
				ST_HSUM: begin
					if (IS_POW2)
						row_q <= hsum[ROW_W-1:0] & ROW_W'(BUCKETS - 1);
				end
				ST_HMOD: begin
					if (hcnt_q == 3'd7)
						row_q <= rem_step[ROW_W-1:0];
				end
				ST_UPD: begin
					if (!best_v_q)
						serial_q <= serial_q + 64'd1;
				end
				ST_SW_WR:  row_q <= row_last ? '0 : row_q + ROW_W'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_vrd_q <= vrd_q;
			res_rep_q <= rep_q;
			res_rm_q  <= rm_q;
		end
		case (st_q)
			ST_IDLE: begin
				vrd_q <= VERDICT_NONE;
				rep_q <= 1'b0;
				rm_q  <= '0;
			end
			ST_HSUM: begin
				sum_q  <= hsum;
				rem_q  <= '0;
				hcnt_q <= '0;
			end
			ST_HMOD: begin
				sum_q  <= {sum_q[27:0], 4'h0};
				rem_q  <= rem_step;
				hcnt_q <= hcnt_q + 3'd1;
			end
			ST_RD: begin
				way_q    <= '0;
				best_v_q <= 1'b0;
				inv_v_q  <= 1'b0;
			end
			ST_SCAN: begin
				way_q <= way_q + WAY_W'(1);
				if (cur.valid && (fw || rv) && (!best_v_q || cur.serial > best_ser_q)) begin
					best_v_q   <= 1'b1;
					best_way_q <= way_q;
					best_fw_q  <= fw;
					best_ser_q <= cur.serial;
				end
				if (!cur.valid && !inv_v_q) begin
					inv_v_q   <= 1'b1;
					inv_way_q <= way_q;
				end
				if (way_q == '0 || cur.serial < old_ser_q) begin
					old_way_q <= way_q;
					old_ser_q <= cur.serial;
				end
			end
			ST_UPD: begin
				upd_q       <= upd_d;
				sel_way_q   <= sel_way;
				miss_full_q <= !best_v_q && !inv_v_q;
			end
			ST_WR: begin
				rep_q <= miss_full_q;
				if (!best_v_q)
					vrd_q <= VERDICT_CLIENT;
				else if (best_fw_q)
					vrd_q <= (upd_q.fwd_bytes > byte_lim_q || upd_q.fwd_pkts > pkt_lim_q)
						? VERDICT_NONE : VERDICT_CLIENT;
				else
					vrd_q <= (upd_q.rev_bytes > byte_lim_q || upd_q.rev_pkts > pkt_lim_q)
						? VERDICT_NONE : VERDICT_SERVER;
			end
			ST_SW_CHK: kill_q <= kill;
			ST_SW_WR:  rm_q   <= rm_q + 13'($countones(kill_q));
			default: ;
		endcase
	end

	// one memory port: never a read and a write in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> !mem_we)
		else $error("table read and write in the same cycle");

	// a replaced entry only comes from a packet miss
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) && res.entry_replaced
			|-> res.verdict == VERDICT_CLIENT && res.removed_count == 13'd0)
		else $error("replacement flagged outside a packet insert");

	// the walk ends after the last row
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_SW_WR && row_last |=> st_q == ST_DONE)
		else $error("sweep did not finish after last row");

	// no item is taken while the table is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_CLR |-> !pkt.ready && !res.valid)
		else $error("item handshake during clearing pass");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for connection_flow_tracker_unit
// predicts verdict, replacement and removal counts from its own copy of the flow table
// depends on cft_pkg, cft_if and the flow tracker RTL
`default_nettype none

module tb_top;
	import cft_pkg::*;

	localparam int NUM_ROWS = 1024;
	localparam int NUM_WAYS = 4;
	localparam int NUM_ENTRIES = NUM_ROWS * NUM_WAYS;

	typedef struct {
		cmd_t        cmd;
		bit          v6;
		bit [63:0]   sh, sl, dh, dl;
		bit [15:0]   sp, dp;
		bit [7:0]    proto;
		bit [15:0]   nbytes;
		bit [7:0]    flags;
		bit [31:0]   now;
	} pkt_item_t;

	typedef struct {
		bit [1:0]  verdict;
		bit        replaced;
		bit [12:0] removed;
	} flow_result_t;

	typedef struct {
		bit          used;
		bit [63:0]   sh, sl, dh, dl;
		bit [31:0]   ports;
		bit [7:0]    proto;
		bit [15:0]   flags;
		bit [31:0]   fwd_bytes, fwd_pkts, rev_bytes, rev_pkts;
		bit [31:0]   last_seen;
		bit [63:0]   serial;
	} flow_entry_t;

	class flow_scoreboard;
		bit [31:0]    byte_lim, pkt_lim, long_idle;
		flow_entry_t  tbl[NUM_ENTRIES];
		bit [63:0]    serial_ctr;
		flow_result_t verdict_q[$];
		int           errors;

		function new();
			byte_lim = RST_BYTE_LIMIT;
			pkt_lim = RST_PKT_LIMIT;
			long_idle = RST_LONG_IDLE;
			serial_ctr = 0;
			errors = 0;
			foreach (tbl[i]) tbl[i].used = 0;
		endfunction

		function void set_reg(logic [1:0] idx, bit [31:0] v);
			case (idx)
				CFG_BYTE_LIMIT: byte_lim = v;
				CFG_PKT_LIMIT:  pkt_lim = v;
				CFG_LONG_IDLE:  long_idle = v;
				default: ;
			endcase
		endfunction

		function bit flow_hit(int i, bit v6, bit [63:0] ah, bit [63:0] al, bit [63:0] bh,
				bit [63:0] bl, bit [15:0] ap, bit [15:0] bp);
			if (tbl[i].ports != {ap, bp}) return 0;
			if (!v6) return tbl[i].sh[63:32] == ah[63:32] && tbl[i].dh[63:32] == bh[63:32];
			return tbl[i].sh == ah && tbl[i].sl == al && tbl[i].dh == bh && tbl[i].dl == bl;
		endfunction

		function bit timed_out(int i, bit [31:0] now);
			bit [31:0] idle;
			bit [7:0]  sf, df;
			idle = (now >= tbl[i].last_seen) ? now - tbl[i].last_seen : 0;
			sf = tbl[i].flags[7:0];
			df = tbl[i].flags[15:8];
			if (tbl[i].proto == PROTO_TCP) begin
				if ((sf & FLAG_FIN) != 0 && (df & FLAG_FIN) != 0 && idle > IDLE_CLOSED) return 1;
				if (((sf | df) & FLAG_RST) != 0 && idle > IDLE_CLOSED) return 1;
				if (((sf & FLAG_SYN_ACK) == 0 || (df & FLAG_SYN_ACK) == 0) &&
						idle > IDLE_HALF_OPEN) return 1;
				if (((sf | df) & FLAG_SYN_ACK) != 0 && idle > IDLE_OPEN) return 1;
				return idle > long_idle;
			end
			if (tbl[i].proto == PROTO_UDP && idle > IDLE_SHORT) return 1;
			if (tbl[i].proto == PROTO_ICMP || tbl[i].proto == PROTO_ICMP6)
				return idle > IDLE_SHORT;
			return idle > long_idle;
		endfunction

		function void note_input(pkt_item_t it);
			flow_result_t r;
			bit [31:0]    sum;
			int           base, pick, slot;
			bit           fw, rv, to_server;
			r = '{default: 0};
			case (it.cmd)
				CMD_PACKET: begin
					sum = it.sh[63:32] + it.dh[63:32];
					if (it.v6)
						sum += it.sh[31:0] + it.sl[63:32] + it.sl[31:0] + it.dh[31:0] +
							it.dl[63:32] + it.dl[31:0];
					base = (sum % NUM_ROWS) * NUM_WAYS;
					pick = -1;
					to_server = 0;
					for (int i = base; i < base + NUM_WAYS; i++) begin
						if (!tbl[i].used) continue;
						fw = flow_hit(i, it.v6, it.sh, it.sl, it.dh, it.dl, it.sp, it.dp);
						rv = flow_hit(i, it.v6, it.dh, it.dl, it.sh, it.sl, it.dp, it.sp);
						if ((fw || rv) && (pick < 0 || tbl[i].serial > tbl[pick].serial)) begin
							pick = i;
							to_server = !fw;
						end
					end
					if (pick >= 0) begin
						tbl[pick].last_seen = it.now;
						if (!to_server) begin
							tbl[pick].flags[7:0] |= it.flags;
							tbl[pick].fwd_bytes += it.nbytes;
							tbl[pick].fwd_pkts += 1;
							r.verdict = (tbl[pick].fwd_bytes > byte_lim ||
								tbl[pick].fwd_pkts > pkt_lim) ? VERDICT_NONE : VERDICT_CLIENT;
						end else begin
							tbl[pick].flags[15:8] |= it.flags;
							tbl[pick].rev_bytes += it.nbytes;
							tbl[pick].rev_pkts += 1;
							r.verdict = (tbl[pick].rev_bytes > byte_lim ||
								tbl[pick].rev_pkts > pkt_lim) ? VERDICT_NONE : VERDICT_SERVER;
						end
					end else begin
						slot = -1;
						for (int i = base; i < base + NUM_WAYS; i++)
							if (slot < 0 && !tbl[i].used) slot = i;
						if (slot < 0) begin
							// full row: evict the oldest insertion
							slot = base;
							for (int i = base + 1; i < base + NUM_WAYS; i++)
								if (tbl[i].serial < tbl[slot].serial) slot = i;
							r.replaced = 1;
						end
						serial_ctr += 1;
						tbl[slot] = '{used: 1, sh: it.sh, sl: it.sl, dh: it.dh, dl: it.dl,
							ports: {it.sp, it.dp}, proto: it.proto, flags: {8'h00, it.flags},
							fwd_bytes: it.nbytes, fwd_pkts: 1, rev_bytes: 0, rev_pkts: 0,
							last_seen: it.now, serial: serial_ctr};
						r.verdict = VERDICT_CLIENT;
					end
				end
				CMD_SWEEP, CMD_FLUSH: begin
					foreach (tbl[i])
						if (tbl[i].used && (it.cmd == CMD_FLUSH || timed_out(i, it.now))) begin
							tbl[i].used = 0;
							r.removed += 1;
						end
				end
				default: ;
			endcase
			verdict_q.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(flow_result_t got);
			flow_result_t want;
			if (verdict_q.size() == 0) begin
				report("result item with nothing outstanding");
				return;
			end
			want = verdict_q.pop_front();
			if (got.verdict != want.verdict)
				report($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
			if (got.replaced != want.replaced)
				report($sformatf("entry_replaced %0d, want %0d", got.replaced, want.replaced));
			if (got.removed != want.removed)
				report($sformatf("removed_count %0d, want %0d", got.removed, want.removed));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_pct;
	int   recv_pct;
	bit [31:0] clock_now;

	// flow pool, mostly packed into a few rows so ways fill up
	bit        pool_v6[16];
	bit [63:0] pool_sh[16], pool_sl[16], pool_dh[16], pool_dl[16];
	bit [15:0] pool_sp[16], pool_dp[16];
	bit [7:0]  pool_proto[16];

	flow_scoreboard sb = new();

	cft_pkt_if pkt_ch ();
	cft_res_if res_ch ();
	cft_cfg_if cfg_ch ();

	connection_flow_tracker_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result('{verdict: res_ch.verdict, replaced: res_ch.entry_replaced,
					removed: res_ch.removed_count});
			res_ch.ready <= ($urandom_range(99) >= recv_pct);
		end
	end

	function automatic pkt_item_t mk(cmd_t c, bit v6, bit [63:0] sh, bit [63:0] sl,
			bit [63:0] dh, bit [63:0] dl, bit [15:0] sp, bit [15:0] dp, bit [7:0] proto,
			bit [15:0] nb, bit [7:0] fl, bit [31:0] now);
		pkt_item_t it;
		it = '{cmd: c, v6: v6, sh: sh, sl: sl, dh: dh, dl: dl, sp: sp, dp: dp, proto: proto,
			nbytes: nb, flags: fl, now: now};
		return it;
	endfunction

	task automatic send_item(input pkt_item_t it);
		pkt_ch.valid <= 1;
		pkt_ch.cmd <= it.cmd;
		pkt_ch.is_ipv6 <= it.v6;
		pkt_ch.src_ip_hi <= it.sh;
		pkt_ch.src_ip_lo <= it.sl;
		pkt_ch.dst_ip_hi <= it.dh;
		pkt_ch.dst_ip_lo <= it.dl;
		pkt_ch.sport <= it.sp;
		pkt_ch.dport <= it.dp;
		pkt_ch.ip_protocol <= it.proto;
		pkt_ch.payload_bytes <= it.nbytes;
		pkt_ch.tcp_flag_bits <= it.flags;
		pkt_ch.now_seconds <= it.now;
		do @(posedge clk); while (!pkt_ch.ready);
		sb.note_input(it);
		if ($urandom_range(99) < send_pct) begin
			pkt_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input bit [31:0] v);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_reg(idx, v);
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		pkt_ch.valid <= 0;
		while (sb.verdict_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic pkt_item_t random_item();
		pkt_item_t it;
		int        f, pick;
		bit [7:0]  flag_menu[6];
		flag_menu = '{FLAG_FIN, FLAG_RST, FLAG_SYN_ACK, 8'h02, 8'h10, 8'h00};
		pick = $urandom_range(99);
		if (pick < 3) begin
			it = mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
				clock_now + $urandom_range(0, 400));
			if ($urandom_range(3) == 0) it.now = $urandom;
		end else if (pick < 4) begin
			it = mk(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, clock_now);
		end else if (pick < 5) begin
			it = mk(CMD_RSVD, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
				8'($urandom), 16'($urandom), 8'($urandom), $urandom);
		end else if (pick < 25) begin
			// unrelated flow with every field random
			it = mk(CMD_PACKET, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
				8'($urandom), 16'($urandom), 8'($urandom), $urandom);
		end else begin
			f = $urandom_range(15);
			clock_now += $urandom_range(0, 30);
			it = mk(CMD_PACKET, pool_v6[f], pool_sh[f], pool_sl[f], pool_dh[f], pool_dl[f],
				pool_sp[f], pool_dp[f], pool_proto[f],
				($urandom_range(9) == 0) ? 16'hffff : 16'($urandom_range(0, 1500)),
				($urandom_range(3) == 0) ? 8'($urandom) : flag_menu[$urandom_range(5)],
				($urandom_range(19) == 0) ? clock_now - $urandom_range(0, 50) : clock_now);
			if (!it.v6) begin
				// ipv4 keys only on word0, the rest is noise
				it.sh[31:0] = $urandom;
				it.dh[31:0] = $urandom;
				it.sl = {$urandom, $urandom};
				it.dl = {$urandom, $urandom};
			end
			if ($urandom_range(1)) begin
				it.sh = it.dh;
				it.sl = it.dl;
				it.dh = pool_sh[f];
				it.dl = pool_sl[f];
				it.sp = pool_dp[f];
				it.dp = pool_sp[f];
				if (!it.v6) it.dh[31:0] = $urandom;
			end
		end
		return it;
	endfunction

	task automatic build_pool();
		bit [31:0] rows[3];
		bit [31:0] sw;
		bit [7:0]  proto_menu[6];
		rows = '{$urandom_range(NUM_ROWS - 1), $urandom_range(NUM_ROWS - 1),
			$urandom_range(NUM_ROWS - 1)};
		proto_menu = '{PROTO_TCP, PROTO_TCP, PROTO_UDP, PROTO_ICMP, PROTO_ICMP6, 8'd47};
		for (int f = 0; f < 16; f++) begin
			pool_v6[f] = (f % 4 == 3);
			pool_sl[f] = {$urandom, $urandom};
			pool_dl[f] = {$urandom, $urandom};
			sw = $urandom;
			pool_sh[f] = {sw, $urandom};
			pool_dh[f] = {rows[f % 3] - sw + NUM_ROWS * $urandom_range(0, 1000), $urandom};
			pool_sp[f] = 16'($urandom);
			pool_dp[f] = 16'($urandom);
			pool_proto[f] = proto_menu[$urandom_range(5)];
		end
	endtask

	initial begin
		bit [31:0] lim_set[5][3];
		bit [63:0] ones;
		bit [63:0] cl_a, cl_b;
		ones = '1;
		cl_a = {32'h0a000001, 32'h0};
		cl_b = {32'h0a000002, 32'h0};
		lim_set = '{'{RST_BYTE_LIMIT, RST_PKT_LIMIT, RST_LONG_IDLE}, '{0, 0, 0},
			'{32'hffffffff, 32'hffffffff, 32'hffffffff}, '{3000, 3, 30},
			'{$urandom_range(1, 100000), $urandom_range(1, 40), $urandom_range(1, 1000)}};
		arst_n = 0;
		send_pct = 38;
		recv_pct = 48;
		clock_now = 1000;
		pkt_ch.valid = 0;
		pkt_ch.cmd = CMD_PACKET;
		pkt_ch.is_ipv6 = 0;
		pkt_ch.src_ip_hi = 0;
		pkt_ch.src_ip_lo = 0;
		pkt_ch.dst_ip_hi = 0;
		pkt_ch.dst_ip_lo = 0;
		pkt_ch.sport = 0;
		pkt_ch.dport = 0;
		pkt_ch.ip_protocol = 0;
		pkt_ch.payload_bytes = 0;
		pkt_ch.tcp_flag_bits = 0;
		pkt_ch.now_seconds = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = CFG_BYTE_LIMIT;
		cfg_ch.data = 0;
		build_pool();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, both directions, ipv4 word0 keying, each expiry rule
		send_item(mk(CMD_PACKET, 1, ones, ones, ones, ones, 16'hffff, 16'hffff, PROTO_TCP,
			16'hffff, 8'h02, 100));
		send_item(mk(CMD_PACKET, 0, cl_a, 0, cl_b, 0, 1234, 80, PROTO_TCP, 60, 8'h02, 100));
		send_item(mk(CMD_PACKET, 0, cl_b, 0, cl_a, 0, 80, 1234, PROTO_TCP, 60, FLAG_SYN_ACK, 100));
		send_item(mk(CMD_PACKET, 0, cl_a | 64'h5a5a, ones, cl_b | 64'h77, 64'h3, 1234, 80,
			PROTO_TCP, 0, FLAG_FIN, 100));
		send_item(mk(CMD_PACKET, 0, cl_b, 0, cl_a, 0, 80, 1234, PROTO_TCP, 0, FLAG_FIN, 100));
		send_item(mk(CMD_PACKET, 0, 0, 0, 0, 0, 0, 0, PROTO_UDP, 0, 0, 0));
		send_item(mk(CMD_PACKET, 0, cl_a, 0, cl_a, 0, 0, 0, PROTO_ICMP, 8, 0, 100));
		send_item(mk(CMD_PACKET, 1, 1, 2, 3, 4, 0, 0, PROTO_ICMP6, 8, 0, 100));
		send_item(mk(CMD_PACKET, 0, cl_b, 0, cl_b, 0, 5, 6, 8'd47, 8, 0, 100));
		send_item(mk(CMD_PACKET, 0, cl_a, 0, cl_b, 0, 999, 80, PROTO_TCP, 8, FLAG_RST, 100));
		send_item(mk(CMD_PACKET, 0, cl_b, 0, cl_a, 0, 77, 78, PROTO_TCP, 8, 8'h10, 100));
		send_item(mk(CMD_RSVD, 1, ones, ones, ones, ones, 16'hffff, 16'hffff, 8'hff, 16'hffff,
			8'hff, 32'hffffffff));
		send_item(mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 106));
		send_item(mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 111));
		send_item(mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 170));
		// five flows in one row: the fifth evicts the oldest
		for (int k = 0; k < 5; k++)
			send_item(mk(CMD_PACKET, 0, {32'(k + 1), 32'h0}, 0, {32'(7 - (k + 1)), 32'h0}, 0,
				16'(k), 16'(k), PROTO_UDP, 1, 0, 200));
		send_item(mk(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hffffffff));
		send_item(mk(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			write_reg(CFG_BYTE_LIMIT, lim_set[ph][0]);
			write_reg(CFG_PKT_LIMIT, lim_set[ph][1]);
			write_reg(CFG_LONG_IDLE, lim_set[ph][2]);
			case (ph * 3 / 5)
				0: begin send_pct = 38; recv_pct = 48; end
				1: begin send_pct = 48; recv_pct = 38; end
				default: begin send_pct = 0; recv_pct = 0; end
			endcase
			for (int n = 0; n < 206; n++)
				send_item(random_item());
		end

		wait_drained();
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#24000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
src/cft_pkg.sv
src/cft_if.sv
src/connection_flow_tracker_unit.sv
tb/sv/tb_top.sv
